/* rtl/knt_pkg.sv */
// ----------------------------------------------------------------------------
// knt_pkg
// shared types, constants and character class helpers for the tokenizer
// ----------------------------------------------------------------------------
package knt_pkg;

  localparam int NUMBER_BITS      = 31;
  localparam int LINE_BITS        = 16;
  localparam int NAME_LENGTH_BITS = 8;

  localparam int KIND_W  = 4;
  localparam int VALUE_W = 31;
  localparam int LINE_W  = 16;
  localparam int CHAR_W  = 8;

  localparam int KW_COUNT = 5;
  localparam int KW_POS_W = 4;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [NUMBER_BITS-1:0]      NUM_MAX  = '1;
  localparam logic [LINE_BITS-1:0]        LINE_MAX = '1;
  localparam logic [NAME_LENGTH_BITS-1:0] NAME_MAX = '1;
  localparam logic [KW_COUNT-1:0]         KW_ALL   = '1;

  localparam logic [KIND_W-1:0] KIND_NAME   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_NUMBER = 4'd1;
  localparam logic [KIND_W-1:0] KIND_KW0    = 4'd2;
  localparam logic [KIND_W-1:0] KIND_BAD    = 4'd7;
  localparam logic [KIND_W-1:0] KIND_END    = 4'd8;

  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_NAME   = 4'b0010,
    MODE_NUMBER = 4'b0100,
    MODE_HALTED = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [LINE_W-1:0]  line;
    logic               ovf;
    logic               last;
  } result_t;

  // keyword lengths
  function automatic logic [NAME_LENGTH_BITS-1:0] kw_len(input int k);
    logic [NAME_LENGTH_BITS-1:0] len;
    case (k)
      0:       len = NAME_LENGTH_BITS'(6);
      1:       len = NAME_LENGTH_BITS'(6);
      2:       len = NAME_LENGTH_BITS'(11);
      3:       len = NAME_LENGTH_BITS'(12);
      default: len = NAME_LENGTH_BITS'(7);
    endcase
    return len;
  endfunction

  // keyword text, one character per position
  function automatic logic [CHAR_W-1:0] kw_char(input int k, input logic [KW_POS_W-1:0] pos);
    logic [12*CHAR_W-1:0] txt;
    case (k)
      0:       txt = {"points", 48'h0};
      1:       txt = {"lignes", 48'h0};
      2:       txt = {"checkpoints", 8'h0};
      3:       txt = "emplacements";
      default: txt = {"arrivee", 40'h0};
    endcase
    if (pos > KW_POS_W'(11)) begin
      return '0;
    end
    return txt[(11 - int'(pos))*CHAR_W +: CHAR_W];
  endfunction

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == CH_UNDER);
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= "0" && c <= "9");
  endfunction

endpackage

/* rtl/keyword_number_tokenizer.sv */
// ----------------------------------------------------------------------------
// keyword_number_tokenizer
// byte-serial tokenizer for names, five keywords, numbers and line breaks
// ----------------------------------------------------------------------------
// input channel: one character byte per request, or an end-of-stream mark
// (in_end_of_stream high) that flushes a pending token, reports an end token
// and returns the scanner to its reset state
// result channel: zero, one or two tokens per request, out_last high on the
// final token a request causes
// a token is registered in the result queue when its request is accepted
// throughput: one request per cycle while in_ready is high; the scanner state
// updates in the cycle of acceptance, and tokens go into a four-entry result
// queue that the receiver drains at one token per cycle while out_ready is
// high, so the two tokens of one request leave it one after the other
// in_ready stays high while two queue slots are free; when the receiver
// stalls the queue fills and in_ready drops, nothing is lost
// reset: scanner idle, line counter at one, queue empty
// a bad character halts the scanner until the next end-of-stream request
// ----------------------------------------------------------------------------
module keyword_number_tokenizer
  import knt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CHAR_W-1:0]  in_char_code,
  input  logic               in_end_of_stream,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KIND_W-1:0]  out_token_kind,
  output logic [VALUE_W-1:0] out_token_value,
  output logic [LINE_W-1:0]  out_line_number,
  output logic               out_overflow,
  output logic               out_last
);

  mode_t                       mode_r, mode_nxt;
  logic [NUMBER_BITS-1:0]      acc_r, acc_nxt;
  logic [NAME_LENGTH_BITS-1:0] len_r, len_nxt;
  logic [KW_COUNT-1:0]         match_r, match_nxt;
  logic [LINE_BITS-1:0]        line_r, line_nxt;
  logic                        ovf_r, ovf_nxt;

  result_t                     mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]            wptr_r, rptr_r;
  logic [CNT_W-1:0]            count_r;

  logic                        in_acc, out_acc;
  logic [1:0]                  n_res;
  result_t                     res0, res1;
  result_t                     flush_res, tail_res;
  logic                        flush_vld;
  logic [LINE_W-1:0]           line_out;

  logic [CHAR_W-1:0]           c;
  logic                        c_let, c_dig;
  logic [NAME_LENGTH_BITS-1:0] base_len;
  logic [KW_COUNT-1:0]         base_match;
  logic [NUMBER_BITS-1:0]      base_acc;
  logic                        base_ovf;
  logic [NUMBER_BITS+3:0]      prod;
  logic [KIND_W-1:0]           kw_kind;
  logic                        kw_hit;

  assign in_ready  = (count_r <= CNT_W'(FIFO_DEPTH - 2));
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (count_r != '0);
  assign out_acc   = out_valid && out_ready;

  assign c        = in_char_code;
  assign c_let    = is_letter(c);
  assign c_dig    = is_digit(c);
  assign line_out = LINE_W'(line_r);

  // pending token as it stands in the registers
  always_comb begin
    kw_kind = KIND_NAME;
    kw_hit  = 1'b0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (match_r[k] && (len_r == kw_len(k))) begin
        kw_kind = KIND_KW0 + KIND_W'(k);
        kw_hit  = 1'b1;
      end
    end
    flush_vld = (mode_r == MODE_NAME) || (mode_r == MODE_NUMBER);
    flush_res = '0;
    flush_res.line = line_out;
    if (mode_r == MODE_NUMBER) begin
      flush_res.kind  = KIND_NUMBER;
      flush_res.value = VALUE_W'(acc_r);
      flush_res.ovf   = ovf_r;
    end else if (kw_hit) begin
      flush_res.kind = kw_kind;
    end else begin
      flush_res.kind  = KIND_NAME;
      flush_res.value = VALUE_W'(len_r);
      flush_res.ovf   = ovf_r;
    end
  end

  // scanner next state and tokens for the accepted request
  always_comb begin
    mode_nxt   = mode_r;
    acc_nxt    = acc_r;
    len_nxt    = len_r;
    match_nxt  = match_r;
    line_nxt   = line_r;
    ovf_nxt    = ovf_r;
    n_res      = 2'd0;
    res0       = '0;
    res1       = '0;
    tail_res   = '0;
    base_len   = len_r;
    base_match = match_r;
    base_acc   = acc_r;
    base_ovf   = ovf_r;
    prod       = '0;

    if (in_acc) begin
      tail_res.line = line_out;
      if (in_end_of_stream) begin
        tail_res.kind = KIND_END;
        tail_res.last = 1'b1;
        if (flush_vld) begin
          res0  = flush_res;
          res1  = tail_res;
          n_res = 2'd2;
        end else begin
          res0  = tail_res;
          n_res = 2'd1;
        end
        mode_nxt  = MODE_IDLE;
        acc_nxt   = '0;
        len_nxt   = '0;
        match_nxt = KW_ALL;
        line_nxt  = LINE_BITS'(1);
        ovf_nxt   = 1'b0;
      end else if (mode_r != MODE_HALTED) begin
        if ((mode_r == MODE_NAME && (c_let || c_dig)) ||
            (mode_r == MODE_NUMBER && c_dig)) begin
          // token continues, work from current registers
        end else begin
          base_len   = '0;
          base_match = KW_ALL;
          base_acc   = '0;
          base_ovf   = 1'b0;
        end

        if ((mode_r == MODE_NAME && (c_let || c_dig)) ||
            (mode_r != MODE_NUMBER && mode_r != MODE_NAME && c_let) ||
            (mode_r == MODE_NUMBER && !c_dig && c_let) ||
            (mode_r == MODE_NAME && !(c_let || c_dig) && c_let)) begin
          mode_nxt = MODE_NAME;
          if (base_len >= NAME_MAX) begin
            ovf_nxt   = 1'b1;
            match_nxt = '0;
            len_nxt   = base_len;
          end else begin
            ovf_nxt   = base_ovf;
            match_nxt = base_match;
            for (int k = 0; k < KW_COUNT; k++) begin
              if (base_len >= kw_len(k) ||
                  kw_char(k, KW_POS_W'(base_len)) != c) begin
                match_nxt[k] = 1'b0;
              end
            end
            len_nxt = base_len + NAME_LENGTH_BITS'(1);
          end
        end else if (c_dig) begin
          mode_nxt = MODE_NUMBER;
          prod = ({4'b0, base_acc} << 3) + ({4'b0, base_acc} << 1) +
                 (NUMBER_BITS+4)'(c - "0");
          if (prod > {4'b0, NUM_MAX}) begin
            acc_nxt = NUM_MAX;
            ovf_nxt = 1'b1;
          end else begin
            acc_nxt = prod[NUMBER_BITS-1:0];
            ovf_nxt = base_ovf;
          end
        end else begin
          mode_nxt = MODE_IDLE;
          if (c == CH_NL) begin
            if (line_r < LINE_MAX) begin
              line_nxt = line_r + LINE_BITS'(1);
            end
          end else if (c == CH_SPACE || c == CH_CR) begin
            line_nxt = line_r;
          end else begin
            mode_nxt       = MODE_HALTED;
            tail_res.kind  = KIND_BAD;
            tail_res.value = VALUE_W'(c);
          end
        end

        // emit flushed token, then a bad char if any
        if (flush_vld && mode_nxt != mode_r) begin
          res0  = flush_res;
          n_res = 2'd1;
          if (mode_nxt == MODE_HALTED) begin
            res1  = tail_res;
            n_res = 2'd2;
          end
        end else if (flush_vld && !((mode_r == MODE_NAME && (c_let || c_dig)) ||
                                    (mode_r == MODE_NUMBER && c_dig))) begin
          res0  = flush_res;
          n_res = 2'd1;
        end else if (mode_nxt == MODE_HALTED) begin
          res0  = tail_res;
          n_res = 2'd1;
        end
        if (n_res == 2'd2) begin
          res1.last = 1'b1;
        end else if (n_res == 2'd1) begin
          res0.last = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      acc_r   <= '0;
      len_r   <= '0;
      match_r <= KW_ALL;
      line_r  <= LINE_BITS'(1);
      ovf_r   <= 1'b0;
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
      len_r   <= len_nxt;
      match_r <= match_nxt;
      line_r  <= line_nxt;
      ovf_r   <= ovf_nxt;
      wptr_r  <= wptr_r + PTR_W'(n_res);
      if (out_acc) begin
        rptr_r <= rptr_r + PTR_W'(1);
      end
      count_r <= count_r + CNT_W'(n_res) - CNT_W'(out_acc);
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      mem_r[wptr_r] <= res0;
    end
    if (n_res == 2'd2) begin
      mem_r[wptr_r + PTR_W'(1)] <= res1;
    end
  end

  assign out_token_kind  = mem_r[rptr_r].kind;
  assign out_token_value = mem_r[rptr_r].value;
  assign out_line_number = mem_r[rptr_r].line;
  assign out_overflow    = mem_r[rptr_r].ovf;
  assign out_last        = mem_r[rptr_r].last;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue count out of range");

  a_eos_reinit : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_end_of_stream) |=>
      (mode_r == MODE_IDLE && line_r == LINE_BITS'(1) && count_r != '0))
    else $error("end of stream did not reinitialize scanner");

  a_halt_silent : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_end_of_stream && mode_r == MODE_HALTED) |=>
      (mode_r == MODE_HALTED && count_r <= $past(count_r)))
    else $error("halted scanner produced a token");

  a_line_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0)
    else $error("line counter reached zero");

endmodule
